FILE: src/positional_list_engine_macros.svh
// Assertion macros for the positional list engine checker.
// Used by plm_checker; needs nothing else.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define PLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plm_checker: same-cycle check failed");

// next-cycle implication
`define PLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plm_checker: next-cycle check failed");

`endif

FILE: src/plm_pkg.sv
// Shared constants, codes and types of the positional list engine.
// No dependencies.
`default_nettype none
package plm_pkg;
    localparam int PLM_CAPACITY   = 64;
    localparam int PLM_VALUE_BITS = 32;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LENGTH = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] at;
    } t_cell_ctrl;
endpackage
`default_nettype wire

FILE: src/plm_if.sv
// Request and response channel interfaces of the positional list engine.
// Depends on plm_pkg.
`default_nettype none
interface plm_req_if;
    import plm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;

    modport source (output valid, func, position, new_value, input ready);
    modport sink   (input valid, func, position, new_value, output ready);
endinterface

interface plm_rsp_if;
    import plm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, status, read_value, count, input ready);
    modport sink   (input valid, status, read_value, count, output ready);
endinterface
`default_nettype wire

FILE: src/plm_cell.sv
// One storage cell of the list chain: holds one element, shifts from its
// neighbors on insert/delete, drives its value on the read bus when selected.
// Depends on plm_pkg.
`default_nettype none
module plm_cell #(
    parameter int VALUE_BITS = plm_pkg::PLM_VALUE_BITS,
    parameter int IDX        = 0
) (
    input  wire                        i_clk,
    input  wire plm_pkg::t_cell_ctrl   i_ctrl,
    input  wire logic [VALUE_BITS-1:0] i_new,
    input  wire logic [VALUE_BITS-1:0] i_left,
    input  wire logic [VALUE_BITS-1:0] i_right,
    output logic      [VALUE_BITS-1:0] o_val,
    output logic      [VALUE_BITS-1:0] o_tap
);
    import plm_pkg::*;

    localparam logic [31:0] L_IDX = 32'(IDX);

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] n_val;
    logic [31:0]           w_at;
    logic                  w_hit;
    logic                  w_after;

    assign w_at    = 32'(i_ctrl.at);
    assign w_hit   = (L_IDX == w_at);
    assign w_after = (L_IDX > w_at);

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            if (w_hit) begin
                n_val = i_new;
            end else if (w_after) begin
                n_val = i_left;
            end
        end else if (i_ctrl.del) begin
            if (w_hit || w_after) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_tap = w_hit ? r_val : '0;
endmodule
`default_nettype wire

FILE: src/positional_list_engine.sv
// Top level of the positional list engine: request register, length
// register, row of plm_cell, response register. Depends on plm_pkg, plm_if.
//
//  channel   dir  payload                          handshake
//  i_req     in   func, position, new_value        valid/ready
//  o_rsp     out  status, read_value, count        valid/ready
//
// Each request is first registered; then the cell row is updated, where
// every cell shifts in parallel. The read of the selected cell goes
// through an OR bus over the row. A new request is taken while a response
// waits; execution stalls only while the response register is still full.
// Reset (i_rst_n low, synchronous) empties the list; cell contents are kept.
`default_nettype none
module positional_list_engine #(
    parameter int CAPACITY   = plm_pkg::PLM_CAPACITY,
    parameter int VALUE_BITS = plm_pkg::PLM_VALUE_BITS
) (
    input wire       i_clk,
    input wire       i_rst_n,
    plm_req_if.sink   i_req,
    plm_rsp_if.source o_rsp
);
    import plm_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam logic [31:0] L_CAP = 32'(CAPACITY);

    logic                  r_req_vld;
    logic [FUNC_W-1:0]     r_func;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_W-1:0]     r_new;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      n_len;

    logic                  r_out_vld;
    t_status               r_status;
    t_status               n_status;
    logic [DATA_W-1:0]     r_rd;
    logic [DATA_W-1:0]     n_rd;
    logic [COUNT_W-1:0]    r_count;

    logic                  w_accept;
    logic                  w_exec;
    logic [31:0]           w_pos32;
    logic [31:0]           w_len32;
    t_cell_ctrl            w_ctrl;
    logic [VALUE_BITS-1:0] w_new;
    logic [VALUE_BITS-1:0] w_val [CAPACITY];
    logic [VALUE_BITS-1:0] w_tap [CAPACITY];
    logic [VALUE_BITS-1:0] w_rd_raw;
    logic signed [63:0]    w_rd_ext;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_exec      = r_req_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_req_vld;

    assign w_pos32  = 32'(r_pos);
    assign w_len32  = 32'(r_len);
    assign w_new    = VALUE_BITS'({32'b0, r_new});
    assign w_rd_ext = 64'(signed'(w_rd_raw));

    always_comb begin
        w_rd_raw = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_raw = w_rd_raw | w_tap[k];
        end
    end

    always_comb begin
        n_len      = r_len;
        n_status   = ST_OK;
        n_rd       = '0;
        w_ctrl.ins = 1'b0;
        w_ctrl.del = 1'b0;
        w_ctrl.at  = r_pos - POS_W'(1);
        unique case (r_func)
            FN_INSERT: begin
                if (w_pos32 == 32'd0 || w_pos32 > w_len32 + 32'd1) begin
                    n_status = ST_RANGE;
                end else if (w_len32 >= L_CAP) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.ins = w_exec;
                    n_len      = r_len + LEN_W'(1);
                end
            end
            FN_DELETE: begin
                if (w_pos32 == 32'd0 || w_pos32 > w_len32) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctrl.del = w_exec;
                    n_rd       = w_rd_ext[31:0];
                    n_len      = r_len - LEN_W'(1);
                end
            end
            FN_GET: begin
                if (w_pos32 == 32'd0 || w_pos32 > w_len32) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd = w_rd_ext[31:0];
                end
            end
            FN_LENGTH: begin
            end
            FN_CLEAR: begin
                n_len = '0;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left;
        logic [VALUE_BITS-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_new;
        end else begin : g_mid
            assign w_left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_inner
            assign w_right = w_val[g+1];
        end
        plm_cell #(
            .VALUE_BITS(VALUE_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_new  (w_new),
            .i_left (w_left),
            .i_right(w_right),
            .o_val  (w_val[g]),
            .o_tap  (w_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_len     <= '0;
        end else begin
            if (w_accept) begin
                r_req_vld <= 1'b1;
            end else if (w_exec) begin
                r_req_vld <= 1'b0;
            end
            if (w_exec) begin
                r_out_vld <= 1'b1;
                r_len     <= n_len;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_req.func;
            r_pos  <= i_req.position;
            r_new  <= unsigned'(i_req.new_value);
        end
        if (w_exec) begin
            r_status <= n_status;
            r_rd     <= n_rd;
            r_count  <= COUNT_W'(n_len);
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = signed'(r_rd);
    assign o_rsp.count      = r_count;
endmodule
`default_nettype wire

FILE: src/plm_checker.sv
// Port-level assertions for positional_list_engine, attached with bind.
// Depends on plm_pkg and positional_list_engine_macros.svh.
`default_nettype none
`include "positional_list_engine_macros.svh"
module plm_checker #(
    parameter int CAPACITY = plm_pkg::PLM_CAPACITY
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_rsp_valid,
    input wire                               i_rsp_ready,
    input wire logic [plm_pkg::STATUS_W-1:0] i_rsp_status,
    input wire logic [plm_pkg::DATA_W-1:0]   i_rsp_read_value,
    input wire logic [plm_pkg::COUNT_W-1:0]  i_rsp_count
);
    import plm_pkg::*;

    localparam logic [31:0]        L_CAP   = 32'(CAPACITY);
    localparam logic [COUNT_W-1:0] L_CAP_C = COUNT_W'(CAPACITY);

    logic                                   w_cnt_ok;
    logic                                   w_full;
    logic                                   w_err;
    logic                                   w_stall;
    logic [STATUS_W+DATA_W+COUNT_W-1:0]     w_rsp_word;

    assign w_cnt_ok   = (32'(i_rsp_count) <= L_CAP) || (CAPACITY > 127);
    assign w_full     = i_rsp_valid && (i_rsp_status == ST_FULL);
    assign w_err      = i_rsp_valid && (i_rsp_status != ST_OK);
    assign w_stall    = i_rsp_valid && !i_rsp_ready;
    assign w_rsp_word = {i_rsp_status, i_rsp_read_value, i_rsp_count};

    `PLM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, i_rsp_valid, w_cnt_ok)
    `PLM_ASSERT_NOW(a_full_count, i_clk, i_rst_n, w_full, i_rsp_count == L_CAP_C)
    `PLM_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, w_err, i_rsp_read_value == '0)
    `PLM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, i_rsp_valid && $stable(w_rsp_word))
endmodule

bind positional_list_engine plm_checker #(
    .CAPACITY(CAPACITY)
) u_plm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_read_value(o_rsp.read_value),
    .i_rsp_count     (o_rsp.count)
);
`default_nettype wire
